>>> src/skfms_pkg.sv
// shared types and constants for the sorted-key first-match search block
package skfms_pkg;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned IDX_W = 8;
	localparam int unsigned IDX_N = 1 << IDX_W;
	localparam int unsigned CNT_W = 9;
	localparam int unsigned DEFAULT_TABLE_DEPTH = 256;

	// configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_SEL_BIT = 2;
	localparam logic REG_ENTRY_COUNT = 1'b0;

	// item kinds
	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

endpackage

>>> src/skfms_if.sv
// valid/ready channel interfaces for load/query items and search results
interface skfms_in_if import skfms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [IDX_W-1:0] entry_index;
	logic [KEY_W-1:0] search_key;

	modport source (output valid, output action, output entry_index, output search_key,
		input ready);
	modport sink (input valid, input action, input entry_index, input search_key,
		output ready);
endinterface

interface skfms_out_if import skfms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [IDX_W-1:0] first_index;

	modport source (output valid, output found, output first_index, input ready);
	modport sink (input valid, input found, input first_index, output ready);
endinterface

>>> src/sorted_key_first_match_search.sv
// A query makes up to floor(log2(n)) + 1 table reads for n entries in use, one per
// cycle, and then registers the result; with no entries in use it makes no read.
// Load items write the table RAM in the cycle they are transferred, one per cycle while idle.
// One item is in work at a time: a query blocks the input until its result is registered,
// longer while the result waits on the sink; the single RAM read port sets the pace.
// Reset clears the entry count and the control state; the table stays undefined until loaded.
module sorted_key_first_match_search import skfms_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	skfms_in_if.sink              req,
	skfms_out_if.source           rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [CNT_W-1:0] entry_count;

	// configuration registers
	skfms_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.entry_count (entry_count)
	);

	// table and search sequencer
	skfms_search #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_count (entry_count),
		.req         (req),
		.rsp         (rsp)
	);

endmodule

>>> src/skfms_ram.sv
// generic single-write, single-read RAM with registered read data
module skfms_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/skfms_cfg.sv
// APB-style configuration register holding the entry count
module skfms_cfg import skfms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [CNT_W-1:0]      entry_count
);

	logic [CNT_W-1:0] entry_count_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (wr_en && (paddr[REG_SEL_BIT] == REG_ENTRY_COUNT)) begin
			entry_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (paddr[REG_SEL_BIT])
			REG_ENTRY_COUNT: prdata = APB_DATA_W'(entry_count_q);
			default:         prdata = '0;
		endcase
	end

	assign entry_count = entry_count_q;

endmodule

>>> src/skfms_search.sv
// bisection sequencer around the key table RAM, one table read per cycle
module skfms_search import skfms_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CNT_W-1:0]  entry_count,
	skfms_in_if.sink          req,
	skfms_out_if.source       rsp
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned NW = AW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP,
		S_DONE
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	logic             found_q;
	logic [IDX_W-1:0] first_index_q;

	logic [NW-1:0]    lo_q, hi_q, mid_q, n_q;
	logic [KEY_W-1:0] key_q;
	logic             hit_q;

	logic             accept, load_go, query_go, slot_free;
	logic [NW-1:0]    n_sat;
	logic [NW-1:0]    c_lo, c_hi, c_mid;
	logic             c_hit, c_go;
	logic [KEY_W-1:0] rd_data;
	logic [AW-1:0]    wr_addr;
	logic             rd_en;

	// load index wrap table, worked out at elaboration
	logic [AW-1:0] wrap_tab [IDX_N];
	for (genvar gi = 0; gi < IDX_N; gi++) begin : g_wrap
		localparam int unsigned WrapIdx = gi % TABLE_DEPTH;
		assign wrap_tab[gi] = AW'(WrapIdx);
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_go   = accept && (req.action == ACT_LOAD);
	assign query_go  = accept && (req.action == ACT_QUERY);
	assign slot_free = !out_valid_q || rsp.ready;
	assign wr_addr   = wrap_tab[req.entry_index];

	// entry count saturated to the table depth
	always_comb begin
		if (32'(entry_count) > TABLE_DEPTH) begin
			n_sat = NW'(TABLE_DEPTH);
		end else begin
			n_sat = NW'(entry_count);
		end
	end

	// next search window: fresh on a query, narrowed by the returned probe
	always_comb begin
		c_lo  = lo_q;
		c_hi  = hi_q;
		c_hit = hit_q;
		if (state_q == S_IDLE) begin
			c_lo  = '0;
			c_hi  = n_sat;
			c_hit = 1'b0;
		end else if (state_q == S_STEP) begin
			if (rd_data < key_q) begin
				c_lo = mid_q + NW'(1);
			end else begin
				c_hi  = mid_q;
				c_hit = (rd_data == key_q);
			end
		end
		c_go  = (c_lo < c_hi);
		c_mid = c_lo + ((c_hi - c_lo) >> 1);
	end

	assign rd_en = c_go && (query_go || (state_q == S_STEP));

	skfms_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (load_go),
		.waddr (wr_addr),
		.wdata (req.search_key),
		.re    (rd_en),
		.raddr (c_mid[AW-1:0]),
		.rdata (rd_data)
	);

	// search window registers
	always_ff @(posedge clk) begin
		if (query_go || (state_q == S_STEP)) begin
			lo_q  <= c_lo;
			hi_q  <= c_hi;
			hit_q <= c_hit;
			mid_q <= c_mid;
		end
		if (query_go) begin
			n_q   <= n_sat;
			key_q <= req.search_key;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			first_index_q <= '0;
		end else begin
			if (rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (query_go) begin
						state_q <= c_go ? S_STEP : S_DONE;
					end
				end
				S_STEP: begin
					if (!c_go) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q   <= 1'b1;
						found_q       <= hit_q;
						first_index_q <= hit_q ? IDX_W'(hi_q) : '0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.first_index = first_index_q;

	// window stays ordered and inside the entries in use
	a_window_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> ((lo_q <= hi_q) && (hi_q <= n_q)))
		else $error("search window out of order");

	// a probe is outstanding only for a non-empty window
	a_step_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |-> ((lo_q < hi_q) && (mid_q < hi_q) && (mid_q >= lo_q)))
		else $error("probe outside search window");

	// a result appears only out of the done state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result without a finished search");

	// a found result points below the entry count
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && hit_q) |-> (hi_q < n_q))
		else $error("hit beyond entries in use");

endmodule
